/* rtl/cau_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, constants and helper functions of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DATA_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int PROD_W      = 64;
  localparam int SUM_W       = 66;
  localparam int XY_W        = 36;
  localparam int Z_W         = 35;
  localparam int IDX_W       = 6;
  localparam int QUO_W       = 33;
  localparam int NUM_CELLS   = 33;
  localparam int SQRT_STEPS  = 32;
  localparam int CORDIC_STEPS = 31;
  localparam int ANG_SHIFT   = 30 - FRAC_W;

  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = Z_W'(64'd1686629713);
  localparam logic signed [Z_W-1:0] ANG_ROUND   = Z_W'(64'd1) << (ANG_SHIFT - 1);
  localparam logic signed [Z_W-1:0] PI_F        = Z_W'(64'd205887);

  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(32'h7fffffff);
  localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

  typedef enum logic [2:0] {
    MODE_ADD  = 3'd0,
    MODE_SUB  = 3'd1,
    MODE_MUL  = 3'd2,
    MODE_DIV  = 3'd3,
    MODE_CONJ = 3'd4,
    MODE_MOD  = 3'd5,
    MODE_ARG  = 3'd6
  } mode_t;

  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic              ovf;
  } sat_t;

  typedef struct packed {
    logic [PROD_W-1:0] r;
    logic [QUO_W-1:0]  qd;
    logic              neg;
    logic              big;
  } div_lane_t;

  typedef struct packed {
    logic [2:0]               mode;
    logic [DATA_W-1:0]        fast_re;
    logic [DATA_W-1:0]        fast_im;
    logic                     fast_ovf;
    logic                     dz;
    logic [PROD_W-1:0]        den;
    div_lane_t                dre;
    div_lane_t                dim;
    logic [PROD_W-1:0]        sq_n;
    logic [PROD_W-1:0]        sq_res;
    logic signed [XY_W-1:0]   cx;
    logic signed [XY_W-1:0]   cy;
    logic signed [Z_W-1:0]    cz;
    logic                     on_axis;
    logic                     x_neg;
  } cell_t;

  function automatic sat_t sat_word(input logic signed [SUM_W-1:0] v);
    sat_t s;
    if (v > SAT_MAX) begin
      s.val = 32'h7fffffff;
      s.ovf = 1'b1;
    end else if (v < SAT_MIN) begin
      s.val = 32'h80000000;
      s.ovf = 1'b1;
    end else begin
      s.val = v[DATA_W-1:0];
      s.ovf = 1'b0;
    end
    return s;
  endfunction

  function automatic sat_t sat_mag(input logic neg, input logic [QUO_W-1:0] mag);
    sat_t s;
    if (!neg) begin
      if (mag > 33'h07fffffff) begin
        s.val = 32'h7fffffff;
        s.ovf = 1'b1;
      end else begin
        s.val = mag[DATA_W-1:0];
        s.ovf = 1'b0;
      end
    end else begin
      if (mag > 33'h080000000) begin
        s.val = 32'h80000000;
        s.ovf = 1'b1;
      end else begin
        s.val = -mag[DATA_W-1:0];
        s.ovf = 1'b0;
      end
    end
    return s;
  endfunction

  function automatic logic [29:0] atan_q30(input logic [IDX_W-1:0] i);
    logic [29:0] a;
    case (i)
      6'd0:  a = 30'h3243F6A8;
      6'd1:  a = 30'h1DAC6705;
      6'd2:  a = 30'h0FADBAFC;
      6'd3:  a = 30'h07F56EA6;
      6'd4:  a = 30'h03FEAB76;
      6'd5:  a = 30'h01FFD55B;
      6'd6:  a = 30'h00FFFAAA;
      6'd7:  a = 30'h007FFF55;
      6'd8:  a = 30'h003FFFEA;
      6'd9:  a = 30'h001FFFFD;
      6'd10: a = 30'h000FFFFF;
      6'd11: a = 30'h0007FFFF;
      6'd12: a = 30'h0003FFFF;
      6'd13: a = 30'h0001FFFF;
      6'd14: a = 30'h0000FFFF;
      6'd15: a = 30'h00007FFF;
      6'd16: a = 30'h00003FFF;
      6'd17: a = 30'h00001FFF;
      6'd18: a = 30'h00000FFF;
      6'd19: a = 30'h000007FF;
      6'd20: a = 30'h000003FF;
      6'd21: a = 30'h000001FF;
      6'd22: a = 30'h000000FF;
      6'd23: a = 30'h0000007F;
      6'd24: a = 30'h0000003F;
      6'd25: a = 30'h0000001F;
      6'd26: a = 30'h0000000F;
      6'd27: a = 30'h00000008;
      6'd28: a = 30'h00000004;
      6'd29: a = 30'h00000002;
      6'd30: a = 30'h00000001;
      default: a = 30'h0;
    endcase
    return a;
  endfunction

endpackage

/* rtl/cau_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_front
// Input register, product stage, sum stage and setup of the cell row.
// ----------------------------------------------------------------------------
module cau_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          mode,
  input  logic signed [31:0]  a_re,
  input  logic signed [31:0]  a_im,
  input  logic signed [31:0]  b_re,
  input  logic signed [31:0]  b_im,
  output logic                out_valid,
  output cau_pkg::cell_t      dout,
  input  logic                out_en
);

  logic v0, v1, v2, v3;
  logic en0, en1, en2, en3;

  logic [2:0]         m0, m1, m2;
  logic signed [31:0] ar0, ai0, br0, bi0;

  logic signed [cau_pkg::PROD_W-1:0] p_rr, p_ii, p_ri, p_ir, p_sa, p_sb;
  logic [cau_pkg::DATA_W-1:0] f_re1, f_im1, f_re2, f_im2;
  logic f_ovf1, f_ovf2;
  logic signed [cau_pkg::XY_W-1:0] cx1, cy1, cx2, cy2;
  logic signed [cau_pkg::Z_W-1:0]  cz1, cz2;
  logic axis1, xneg1, axis2, xneg2;

  logic signed [cau_pkg::SUM_W-1:0] s_mre, s_mim, s_nre, s_nim;
  logic [cau_pkg::PROD_W-1:0] den2;

  logic signed [31:0] sqa, sqb;
  logic signed [cau_pkg::XY_W-1:0] cx_next, cy_next;
  logic signed [cau_pkg::Z_W-1:0]  cz_next;
  cau_pkg::sat_t s_a, s_b;
  cau_pkg::cell_t cell_next;
  cau_pkg::sat_t m_re, m_im;
  logic [cau_pkg::PROD_W-1:0] mag_re, mag_im;

  assign en3 = ~v3 | out_en;
  assign en2 = ~v2 | en3;
  assign en1 = ~v1 | en2;
  assign en0 = ~v0 | en1;
  assign in_ready  = en0;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en0) v0 <= in_valid;
      if (en1) v1 <= v0;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      m0  <= mode;
      ar0 <= a_re;
      ai0 <= a_im;
      br0 <= b_re;
      bi0 <= b_im;
    end
  end

  // stage 1: products, short results, CORDIC pre-rotation
  always_comb begin
    sqa = (m0 == cau_pkg::MODE_MOD) ? ar0 : br0;
    sqb = (m0 == cau_pkg::MODE_MOD) ? ai0 : bi0;
    s_a = '0;
    s_b = '0;
    case (m0)
      cau_pkg::MODE_ADD: begin
        s_a = cau_pkg::sat_word(cau_pkg::SUM_W'(ar0) + cau_pkg::SUM_W'(br0));
        s_b = cau_pkg::sat_word(cau_pkg::SUM_W'(ai0) + cau_pkg::SUM_W'(bi0));
      end
      cau_pkg::MODE_SUB: begin
        s_a = cau_pkg::sat_word(cau_pkg::SUM_W'(ar0) - cau_pkg::SUM_W'(br0));
        s_b = cau_pkg::sat_word(cau_pkg::SUM_W'(ai0) - cau_pkg::SUM_W'(bi0));
      end
      cau_pkg::MODE_CONJ: begin
        s_a.val = ar0;
        s_b = cau_pkg::sat_word(-cau_pkg::SUM_W'(ai0));
      end
      default: begin
        s_a = '0;
        s_b = '0;
      end
    endcase
    cx_next = cau_pkg::XY_W'(ar0);
    cy_next = cau_pkg::XY_W'(ai0);
    cz_next = '0;
    if (ar0 < 0) begin
      if (ai0 > 0) begin
        cx_next = cau_pkg::XY_W'(ai0);
        cy_next = -cau_pkg::XY_W'(ar0);
        cz_next = cau_pkg::HALF_PI_Q30;
      end else begin
        cx_next = -cau_pkg::XY_W'(ai0);
        cy_next = cau_pkg::XY_W'(ar0);
        cz_next = -cau_pkg::HALF_PI_Q30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      m1     <= m0;
      p_rr   <= ar0 * br0;
      p_ii   <= ai0 * bi0;
      p_ri   <= ar0 * bi0;
      p_ir   <= ai0 * br0;
      p_sa   <= sqa * sqa;
      p_sb   <= sqb * sqb;
      f_re1  <= s_a.val;
      f_im1  <= s_b.val;
      f_ovf1 <= s_a.ovf | s_b.ovf;
      cx1    <= cx_next;
      cy1    <= cy_next;
      cz1    <= cz_next;
      axis1  <= (ai0 == 0);
      xneg1  <= (ar0 < 0);
    end
  end

  // stage 2: sums of products
  always_ff @(posedge clk) begin
    if (en2) begin
      m2     <= m1;
      s_mre  <= cau_pkg::SUM_W'(p_rr) - cau_pkg::SUM_W'(p_ii);
      s_mim  <= cau_pkg::SUM_W'(p_ri) + cau_pkg::SUM_W'(p_ir);
      s_nre  <= cau_pkg::SUM_W'(p_rr) + cau_pkg::SUM_W'(p_ii);
      s_nim  <= cau_pkg::SUM_W'(p_ir) - cau_pkg::SUM_W'(p_ri);
      den2   <= p_sa[cau_pkg::PROD_W-1:0] + p_sb[cau_pkg::PROD_W-1:0];
      f_re2  <= f_re1;
      f_im2  <= f_im1;
      f_ovf2 <= f_ovf1;
      cx2    <= cx1;
      cy2    <= cy1;
      cz2    <= cz1;
      axis2  <= axis1;
      xneg2  <= xneg1;
    end
  end

  // stage 3: product rounding, divider and root setup
  always_comb begin
    m_re   = cau_pkg::sat_word(s_mre >>> cau_pkg::FRAC_W);
    m_im   = cau_pkg::sat_word(s_mim >>> cau_pkg::FRAC_W);
    mag_re = s_nre[cau_pkg::SUM_W-1] ? cau_pkg::PROD_W'(-s_nre) : cau_pkg::PROD_W'(s_nre);
    mag_im = s_nim[cau_pkg::SUM_W-1] ? cau_pkg::PROD_W'(-s_nim) : cau_pkg::PROD_W'(s_nim);

    cell_next          = '0;
    cell_next.mode     = m2;
    cell_next.fast_re  = f_re2;
    cell_next.fast_im  = f_im2;
    cell_next.fast_ovf = f_ovf2;
    if (m2 == cau_pkg::MODE_MUL) begin
      cell_next.fast_re  = m_re.val;
      cell_next.fast_im  = m_im.val;
      cell_next.fast_ovf = m_re.ovf | m_im.ovf;
    end
    cell_next.dz      = (m2 == cau_pkg::MODE_DIV) && (den2 == '0);
    cell_next.den     = den2;
    cell_next.dre.neg = s_nre[cau_pkg::SUM_W-1];
    cell_next.dre.big = {17'b0, mag_re[63:17]} >= den2;
    cell_next.dre.r   = {17'b0, mag_re[63:17]};
    cell_next.dre.qd  = {mag_re[16:0], 16'b0};
    cell_next.dim.neg = s_nim[cau_pkg::SUM_W-1];
    cell_next.dim.big = {17'b0, mag_im[63:17]} >= den2;
    cell_next.dim.r   = {17'b0, mag_im[63:17]};
    cell_next.dim.qd  = {mag_im[16:0], 16'b0};
    cell_next.sq_n    = den2;
    cell_next.sq_res  = '0;
    cell_next.cx      = cx2;
    cell_next.cy      = cy2;
    cell_next.cz      = cz2;
    cell_next.on_axis = axis2;
    cell_next.x_neg   = xneg2;
  end

  always_ff @(posedge clk) begin
    if (en3) dout <= cell_next;
  end

endmodule

/* rtl/cau_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_cell
// One step of the two divider lanes, the square root and the CORDIC rotation.
// ----------------------------------------------------------------------------
module cau_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [cau_pkg::IDX_W-1:0]   idx,
  input  logic                        in_valid,
  input  cau_pkg::cell_t              din,
  output logic                        in_en,
  output logic                        out_valid,
  output cau_pkg::cell_t              dout,
  input  logic                        out_en
);

  logic v;
  cau_pkg::cell_t nxt;
  logic [cau_pkg::PROD_W-1:0] sq_bit;
  logic [cau_pkg::PROD_W:0]   sq_sum;
  logic [5:0] sq_sh;
  logic signed [cau_pkg::XY_W-1:0] xs, ys;
  logic signed [cau_pkg::Z_W-1:0]  da;

  function automatic cau_pkg::div_lane_t div_step(input cau_pkg::div_lane_t l,
                                                  input logic [cau_pkg::PROD_W-1:0] den);
    cau_pkg::div_lane_t o;
    logic [cau_pkg::PROD_W:0] t;
    logic ge;
    o  = l;
    t  = {l.r, l.qd[cau_pkg::QUO_W-1]};
    ge = t >= {1'b0, den};
    o.r  = ge ? cau_pkg::PROD_W'(t - {1'b0, den}) : t[cau_pkg::PROD_W-1:0];
    o.qd = {l.qd[cau_pkg::QUO_W-2:0], ge};
    return o;
  endfunction

  assign in_en     = ~v | out_en;
  assign out_valid = v;

  always_comb begin
    nxt     = din;
    nxt.dre = div_step(din.dre, din.den);
    nxt.dim = div_step(din.dim, din.den);

    sq_sh  = 6'd62 - {idx[4:0], 1'b0};
    sq_bit = cau_pkg::PROD_W'(1) << sq_sh;
    sq_sum = {1'b0, din.sq_res} + {1'b0, sq_bit};
    if (idx < cau_pkg::IDX_W'(cau_pkg::SQRT_STEPS)) begin
      if ({1'b0, din.sq_n} >= sq_sum) begin
        nxt.sq_n   = din.sq_n - sq_sum[cau_pkg::PROD_W-1:0];
        nxt.sq_res = (din.sq_res >> 1) + sq_bit;
      end else begin
        nxt.sq_res = din.sq_res >> 1;
      end
    end

    xs = din.cx >>> idx;
    ys = din.cy >>> idx;
    da = $signed({5'b0, cau_pkg::atan_q30(idx)});
    if (idx < cau_pkg::IDX_W'(cau_pkg::CORDIC_STEPS)) begin
      if (din.cy > 0) begin
        nxt.cx = din.cx + ys;
        nxt.cy = din.cy - xs;
        nxt.cz = din.cz + da;
      end else begin
        nxt.cx = din.cx - ys;
        nxt.cy = din.cy + xs;
        nxt.cz = din.cz - da;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_en) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_en) dout <= nxt;
  end

endmodule

/* rtl/cau_out.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_out
// Result selection, angle rounding, final saturation and output register.
// ----------------------------------------------------------------------------
module cau_out (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  cau_pkg::cell_t      din,
  output logic                in_en,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         res_re,
  output logic [31:0]         res_im,
  output logic                overflow,
  output logic                divide_by_zero
);

  logic v;
  logic [31:0] re_next, im_next;
  logic ovf_next, dz_next;
  cau_pkg::sat_t q_re, q_im, s_mod;
  logic signed [cau_pkg::Z_W-1:0] ang;

  assign in_en     = ~v | out_ready;
  assign out_valid = v;

  always_comb begin
    q_re  = din.dre.big ? cau_pkg::sat_mag(din.dre.neg, '1)
                        : cau_pkg::sat_mag(din.dre.neg && (din.dre.qd != '0), din.dre.qd);
    q_im  = din.dim.big ? cau_pkg::sat_mag(din.dim.neg, '1)
                        : cau_pkg::sat_mag(din.dim.neg && (din.dim.qd != '0), din.dim.qd);
    s_mod = cau_pkg::sat_mag(1'b0, din.sq_res[cau_pkg::QUO_W-1:0]);
    ang   = (din.cz + cau_pkg::ANG_ROUND) >>> cau_pkg::ANG_SHIFT;
    if (ang > cau_pkg::PI_F) ang = cau_pkg::PI_F;
    if (ang < -cau_pkg::PI_F) ang = -cau_pkg::PI_F;
    if (din.on_axis) ang = din.x_neg ? cau_pkg::PI_F : '0;

    re_next  = din.fast_re;
    im_next  = din.fast_im;
    ovf_next = din.fast_ovf;
    dz_next  = 1'b0;
    case (din.mode)
      cau_pkg::MODE_DIV: begin
        if (din.dz) begin
          re_next  = '0;
          im_next  = '0;
          ovf_next = 1'b0;
          dz_next  = 1'b1;
        end else begin
          re_next  = q_re.val;
          im_next  = q_im.val;
          ovf_next = q_re.ovf | q_im.ovf;
        end
      end
      cau_pkg::MODE_MOD: begin
        re_next  = s_mod.val;
        im_next  = '0;
        ovf_next = s_mod.ovf;
      end
      cau_pkg::MODE_ARG: begin
        re_next  = ang[31:0];
        im_next  = '0;
        ovf_next = 1'b0;
      end
      default: begin
        re_next = din.fast_re;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_en) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_en) begin
      res_re         <= re_next;
      res_im         <= im_next;
      overflow       <= ovf_next;
      divide_by_zero <= dz_next;
    end
  end

endmodule

/* rtl/complex_arith_unit_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arith_unit_top
// Q16.16 complex add, subtract, multiply, divide, conjugate, modulus and
// argument with saturation.
// ----------------------------------------------------------------------------
// One transaction per cycle is accepted unless a stalled output fills the
// pipe. Each passes four front stages (input register, 32x32 products, sums,
// rounding and setup), a row of 33 cells that each take one divider quotient
// bit, plus a square-root bit in the first SQRT_STEPS cells and a CORDIC
// rotation in the first CORDIC_STEPS, and the output register. Stages compact
// around bubbles, so transactions keep entering while a result is held.
module complex_arith_unit_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          mode,
  input  logic signed [31:0]  a_re,
  input  logic signed [31:0]  a_im,
  input  logic signed [31:0]  b_re,
  input  logic signed [31:0]  b_im,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  res_re,
  output logic signed [31:0]  res_im,
  output logic                overflow,
  output logic                divide_by_zero
);

  cau_pkg::cell_t chain_d [cau_pkg::NUM_CELLS+1];
  logic           chain_v [cau_pkg::NUM_CELLS+1];
  logic           chain_en [cau_pkg::NUM_CELLS+1];

  cau_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .a_re      (a_re),
    .a_im      (a_im),
    .b_re      (b_re),
    .b_im      (b_im),
    .out_valid (chain_v[0]),
    .dout      (chain_d[0]),
    .out_en    (chain_en[0])
  );

  for (genvar k = 0; k < cau_pkg::NUM_CELLS; k++) begin : g_cell
    cau_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .idx       (cau_pkg::IDX_W'(k)),
      .in_valid  (chain_v[k]),
      .din       (chain_d[k]),
      .in_en     (chain_en[k]),
      .out_valid (chain_v[k+1]),
      .dout      (chain_d[k+1]),
      .out_en    (chain_en[k+1])
    );
  end

  cau_out u_out (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (chain_v[cau_pkg::NUM_CELLS]),
    .din            (chain_d[cau_pkg::NUM_CELLS]),
    .in_en          (chain_en[cau_pkg::NUM_CELLS]),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .res_re         (res_re),
    .res_im         (res_im),
    .overflow       (overflow),
    .divide_by_zero (divide_by_zero)
  );

endmodule

/* rtl/cau_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks of the complex arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module cau_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] res_re,
  input logic [31:0] res_im,
  input logic        overflow,
  input logic        divide_by_zero
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(res_re) && $stable(res_im))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_by_zero |-> res_re == 32'h0 && res_im == 32'h0 && !overflow)
    else $error("zero divisor result not cleared");

  a_ovf_extreme: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> res_re == 32'h7fffffff || res_re == 32'h80000000 ||
                              res_im == 32'h7fffffff || res_im == 32'h80000000)
    else $error("overflow without a saturated part");

endmodule

bind complex_arith_unit_top cau_checker u_cau_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .res_re         (res_re),
  .res_im         (res_im),
  .overflow       (overflow),
  .divide_by_zero (divide_by_zero)
);

/* test/complex_arith_unit_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arith_unit_checker
// Watches both channels of the complex arithmetic unit, computes the expected
// result of every accepted transaction and compares each returned result, in
// order, field by field.
// ----------------------------------------------------------------------------
module complex_arith_unit_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         mode,
  input  logic signed [31:0] a_re,
  input  logic signed [31:0] a_im,
  input  logic signed [31:0] b_re,
  input  logic signed [31:0] b_im,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] res_re,
  input  logic signed [31:0] res_im,
  input  logic               overflow,
  input  logic               divide_by_zero,
  output int                 errors,
  output int                 pending
);

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               ovf;
    logic               dz;
  } cplx_result_t;

  cplx_result_t expected_q[$];

  localparam longint PI_Q30_L      = 64'd3373259426;
  localparam longint HALF_PI_Q30_L = 64'd1686629713;

  logic [29:0] atan_tab [0:30] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
    30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
    30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
    30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
    30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
    30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002,
    30'h00000001
  };

  assign pending = expected_q.size();

  // {overflow, value}
  function automatic logic [32:0] clip(input logic signed [127:0] v);
    if (v > 128'sh7fffffff) return {1'b1, 32'h7fffffff};
    if (v < -128'sh80000000) return {1'b1, 32'h80000000};
    return {1'b0, v[31:0]};
  endfunction

  function automatic logic [32:0] div_trunc(input logic signed [127:0] num,
                                            input logic signed [127:0] den);
    logic signed [127:0] mag;
    logic signed [127:0] quo;
    mag = (num < 0) ? -num : num;
    quo = (mag <<< 16) / den;
    return clip((num < 0) ? -quo : quo);
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] bt;
    r  = 64'd0;
    bt = 64'd1 << 62;
    while (bt > n) bt = bt >> 2;
    while (bt != 0) begin
      if (n >= r + bt) begin
        n = n - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  function automatic longint to_frac(input longint z);
    return (z + (64'sd1 <<< 13)) >>> 14;
  endfunction

  function automatic longint phase_of(input longint x, input longint y);
    longint z;
    longint t;
    longint xs;
    longint ys;
    longint pif;
    longint v;
    z   = 0;
    pif = to_frac(PI_Q30_L);
    if (y == 0) return (x < 0) ? pif : 0;
    if (x < 0) begin
      if (y > 0) begin
        t = y; y = -x; x = t; z = HALF_PI_Q30_L;
      end else begin
        t = -y; y = x; x = t; z = -HALF_PI_Q30_L;
      end
    end
    for (int i = 0; i < 31; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + longint'(atan_tab[i]);
      end else begin
        x = x - ys; y = y + xs; z = z - longint'(atan_tab[i]);
      end
    end
    v = to_frac(z);
    if (v > pif) v = pif;
    if (v < -pif) v = -pif;
    return v;
  endfunction

  function automatic cplx_result_t compute_result(input logic [2:0] m,
      input logic signed [31:0] ar, input logic signed [31:0] ai,
      input logic signed [31:0] br, input logic signed [31:0] bi);
    cplx_result_t r;
    logic signed [127:0] xr, xi, yr, yi, den;
    logic [32:0] pr, pi;
    xr = 128'(ar); xi = 128'(ai); yr = 128'(br); yi = 128'(bi);
    pr = '0;
    pi = '0;
    r.dz = 1'b0;
    case (m)
      cau_pkg::MODE_ADD: begin
        pr = clip(xr + yr); pi = clip(xi + yi);
      end
      cau_pkg::MODE_SUB: begin
        pr = clip(xr - yr); pi = clip(xi - yi);
      end
      cau_pkg::MODE_MUL: begin
        pr = clip((xr * yr - xi * yi) >>> 16);
        pi = clip((xr * yi + xi * yr) >>> 16);
      end
      cau_pkg::MODE_DIV: begin
        den = yr * yr + yi * yi;
        if (den == 0) begin
          r.dz = 1'b1;
        end else begin
          pr = div_trunc(xr * yr + xi * yi, den);
          pi = div_trunc(xi * yr - xr * yi, den);
        end
      end
      cau_pkg::MODE_CONJ: begin
        pr = {1'b0, ar}; pi = clip(-xi);
      end
      cau_pkg::MODE_MOD: begin
        den = xr * xr + xi * xi;
        pr = clip({64'd0, isqrt64(den[63:0])});
      end
      cau_pkg::MODE_ARG: begin
        pr = clip(128'(phase_of(longint'(ar), longint'(ai))));
      end
      default: ;
    endcase
    r.re  = pr[31:0];
    r.im  = pi[31:0];
    r.ovf = pr[32] | pi[32];
    return r;
  endfunction

  task automatic report_mismatch(input string field, input longint got,
                                 input longint exp_v);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field,
             got, exp_v);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    cplx_result_t e;
    if (!rst) begin
      if (in_valid && in_ready)
        expected_q.push_back(compute_result(mode, a_re, a_im, b_re, b_im));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("[%0t] result with no transaction outstanding", $realtime);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (res_re !== e.re)
            report_mismatch("res_re", longint'(res_re), longint'(e.re));
          if (res_im !== e.im)
            report_mismatch("res_im", longint'(res_im), longint'(e.im));
          if (overflow !== e.ovf)
            report_mismatch("overflow", longint'(overflow), longint'(e.ovf));
          if (divide_by_zero !== e.dz)
            report_mismatch("divide_by_zero", longint'(divide_by_zero),
                            longint'(e.dz));
        end
      end
    end
  end

endmodule

/* test/tb_complex_arith_unit_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_complex_arith_unit_top
// Drives directed corner transactions and then random operand mixes into the
// complex arithmetic unit with random gaps and output stalls; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_complex_arith_unit_top;

  localparam int LATENCY   = 38;
  localparam int MAX_CYCLE = 400000;
  localparam logic signed [31:0] MAXV = 32'sh7fffffff;
  localparam logic signed [31:0] MINV = 32'sh80000000;
  localparam logic signed [31:0] ONE  = 32'sh00010000;
  localparam logic [2:0] MODE_UNUSED = 3'd7;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         mode;
  logic signed [31:0] a_re, a_im, b_re, b_im;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] res_re, res_im;
  logic               overflow;
  logic               divide_by_zero;
  int                 errors;
  int                 pending;
  int                 cycle_cnt;
  bit                 calm;

  complex_arith_unit_top i_dut (
    .clk, .rst, .in_valid, .in_ready, .mode, .a_re, .a_im, .b_re, .b_im,
    .out_valid, .out_ready, .res_re, .res_im, .overflow, .divide_by_zero
  );

  complex_arith_unit_checker i_checker (
    .clk, .rst, .in_valid, .in_ready, .mode, .a_re, .a_im, .b_re, .b_im,
    .out_valid, .out_ready, .res_re, .res_im, .overflow, .divide_by_zero,
    .errors, .pending
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLE) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // output stalls
  int stall_left;
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready  <= 1'b1;
      stall_left <= idle_len();
    end
  end

  task automatic send(input logic [2:0] m, input logic signed [31:0] ar,
                      input logic signed [31:0] ai, input logic signed [31:0] br,
                      input logic signed [31:0] bi);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    a_re <= ar; a_im <= ai; b_re <= br; b_im <= bi;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic signed [31:0] rnd_operand();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
      2: case ($urandom_range(0, 5))
           0: return MAXV;
           1: return MINV;
           2: return 0;
           3: return ONE;
           4: return -ONE;
           default: return 1;
         endcase
      default: return $signed($urandom_range(0, 32'h07ffffff)) - 32'sh04000000;
    endcase
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  initial begin
    logic signed [31:0] bi;
    cycle_cnt = 0;
    calm      = 1'b0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    mode      = cau_pkg::MODE_ADD;
    a_re = 0; a_im = 0; b_re = 0; b_im = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(cau_pkg::MODE_ADD,  MAXV, MINV, MAXV, MINV);
    send(cau_pkg::MODE_ADD,  ONE, -ONE, 3 * ONE, 2 * ONE);
    send(cau_pkg::MODE_SUB,  MINV, MAXV, MAXV, MINV);
    send(cau_pkg::MODE_SUB,  5 * ONE, 0, ONE, -ONE);
    send(cau_pkg::MODE_MUL,  MAXV, MAXV, MAXV, MAXV);
    send(cau_pkg::MODE_MUL,  MINV, MINV, MINV, MINV);
    send(cau_pkg::MODE_MUL,  -ONE, 32'sd3, ONE, -32'sd7);
    send(cau_pkg::MODE_DIV,  ONE, ONE, 0, 0);
    send(cau_pkg::MODE_DIV,  3 * ONE, 4 * ONE, ONE, 2 * ONE);
    send(cau_pkg::MODE_DIV,  MINV, MAXV, 32'sd1, 0);
    send(cau_pkg::MODE_DIV,  -7 * ONE, ONE, 2 * ONE, 0);
    send(cau_pkg::MODE_CONJ, MINV, MINV, 0, 0);
    send(cau_pkg::MODE_CONJ, MAXV, ONE, MINV, MAXV);
    send(cau_pkg::MODE_MOD,  MINV, MINV, 0, 0);
    send(cau_pkg::MODE_MOD,  0, 0, ONE, ONE);
    send(cau_pkg::MODE_MOD,  3 * ONE, -4 * ONE, 0, 0);
    send(cau_pkg::MODE_ARG,  ONE, 0, 0, 0);
    send(cau_pkg::MODE_ARG,  -ONE, 0, 0, 0);
    send(cau_pkg::MODE_ARG,  0, 0, 0, 0);
    send(cau_pkg::MODE_ARG,  0, ONE, 0, 0);
    send(cau_pkg::MODE_ARG,  0, MINV, 0, 0);
    send(cau_pkg::MODE_ARG,  MINV, 32'sd1, 0, 0);
    send(cau_pkg::MODE_ARG,  -ONE, -32'sd1, 0, 0);
    send(MODE_UNUSED, MAXV, MAXV, MAXV, MAXV);

    // hold off until the pipe is empty
    drain();

    for (int n = 0; n < 500; n++) begin
      if (n % 100 == 50) calm = ~calm;
      bi = ($urandom_range(0, 4) == 0) ? 32'sd0 : rnd_operand();
      send(3'($urandom_range(0, 7)), rnd_operand(), rnd_operand(), rnd_operand(), bi);
      if (n == 250) drain();
    end
    drain();

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
